FILE: design/rsbd_pkg.sv
// Shared constants for the rolling-shutter band delay block.
// Field widths, register indexes and register reset values; no dependencies.
package rsbd_pkg;

  localparam int PIX_W      = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int DIM_W      = 7;
  localparam int BC_W       = 4;
  localparam int BI_W       = 7;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HEIGHT  = 8'd3;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 7'd64;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 7'd64;
  localparam logic [BC_W-1:0]  RST_BAND_COUNT   = 4'd8;
  localparam logic [DIM_W-1:0] RST_BAND_HEIGHT  = 7'd8;

  localparam logic [BI_W-1:0] BAND_INDEX_MAX = 7'd127;

endpackage

FILE: design/rsbd_if.sv
// Handshake channels of the rolling-shutter band delay block.
// Pixel input, pixel output and register write; depends on rsbd_pkg.
interface rsbd_in_if import rsbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface rsbd_out_if import rsbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  modport source (output valid, output pixel_out, input ready);
  modport sink (input valid, input pixel_out, output ready);
endinterface

interface rsbd_cfg_if import rsbd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;
  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

FILE: design/rolling_shutter_band_delay_top.sv
// Rolling-shutter band delay: ring of frame buffers in one synchronous memory.
// An accepted word passes the read stage (pix1_q, rdata_q), then the output register (out_q).
// Throughput: one word per cycle unless the output stalls; a memory write per word, a read per delayed word.
// Reset clears counters, output valids and restores register defaults.
// The frame memory is not cleared; entries are read only after being written.
// Depends on rsbd_pkg and the channel interfaces in rsbd_if.
module rolling_shutter_band_delay_top import rsbd_pkg::*; #(
  parameter int MAX_BANDS  = 8,
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsbd_cfg_if.sink    cfg_i,
  rsbd_in_if.sink     pix_i,
  rsbd_out_if.source  pix_o
);

  localparam int SLOT_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int FS_W   = $clog2(MAX_BANDS + 2);
  localparam int CR_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W  = ((CR_W > DIM_W) ? CR_W : DIM_W) + 1;
  localparam int BK_W   = BI_W + 1;

  localparam logic [CMP_W-1:0]  W_MAX     = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0]  H_MAX     = CMP_W'(MAX_HEIGHT);
  localparam logic [BK_W-1:0]   B_MAX     = BK_W'(MAX_BANDS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_BANDS - 1);

  // configuration registers
  logic [DIM_W-1:0] fw_q, fh_q, bh_q;
  logic [BC_W-1:0]  bcnt_q;
  logic             cfg_acc, cfg_hit;

  // stream position state
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [DIM_W-1:0]  rib_q, rib_d;
  logic [BI_W-1:0]   bi_q, bi_d;
  logic [FS_W-1:0]   fs_q, fs_d;

  logic [CMP_W-1:0]  w_eff, h_eff, fw_ext, fh_ext;
  logic [BK_W-1:0]   bc_eff, bc_ext, dly, slot_ext, rs_sum;
  logic [SLOT_W-1:0] rslot;
  logic              in_acc, use_delay, mem_rd, pass;
  logic              col_last, row_last, rib_last;

  // pipeline
  logic [PIX_W-1:0] frame_mem [MAX_BANDS][MAX_HEIGHT][MAX_WIDTH];
  logic [PIX_W-1:0] rdata_q, pix1_q, out_q;
  logic             v1_q, pass1_q, vo_q, adv1;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign cfg_hit     = cfg_acc && (cfg_i.reg_index == REG_FRAME_WIDTH ||
                                   cfg_i.reg_index == REG_FRAME_HEIGHT ||
                                   cfg_i.reg_index == REG_BAND_COUNT ||
                                   cfg_i.reg_index == REG_BAND_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= RST_FRAME_WIDTH;
      fh_q   <= RST_FRAME_HEIGHT;
      bcnt_q <= RST_BAND_COUNT;
      bh_q   <= RST_BAND_HEIGHT;
    end else if (cfg_acc) begin
      case (cfg_i.reg_index)
        REG_FRAME_WIDTH:  fw_q   <= cfg_i.reg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: fh_q   <= cfg_i.reg_data[DIM_W-1:0];
        REG_BAND_COUNT:   bcnt_q <= cfg_i.reg_data[BC_W-1:0];
        REG_BAND_HEIGHT:  bh_q   <= cfg_i.reg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp geometry
  always_comb begin
    fw_ext = CMP_W'(fw_q);
    fh_ext = CMP_W'(fh_q);
    bc_ext = BK_W'(bcnt_q);
    if (fw_q == '0)          w_eff = CMP_W'(1);
    else if (fw_ext > W_MAX) w_eff = W_MAX;
    else                     w_eff = fw_ext;
    if (fh_q == '0)          h_eff = CMP_W'(1);
    else if (fh_ext > H_MAX) h_eff = H_MAX;
    else                     h_eff = fh_ext;
    if (bcnt_q == '0)        bc_eff = BK_W'(1);
    else if (bc_ext > B_MAX) bc_eff = B_MAX;
    else                     bc_eff = bc_ext;
  end

  assign in_acc = pix_i.valid && pix_i.ready;

  // per-word control
  always_comb begin
    fs_d = fs_q;
    if (col_q == '0 && row_q == '0 && BK_W'(fs_q) < bc_eff + BK_W'(1)) begin
      fs_d = fs_q + FS_W'(1);
    end
    use_delay = (BK_W'(fs_d) > bc_eff) && (bh_q != '0) && (BK_W'(bi_q) < bc_eff);
    dly       = bc_eff - BK_W'(1) - BK_W'(bi_q);
    slot_ext  = BK_W'(slot_q);
    rs_sum    = (slot_ext >= dly) ? slot_ext - dly : slot_ext + B_MAX - dly;
    rslot     = rs_sum[SLOT_W-1:0];
    pass      = !(use_delay && dly != '0);
    mem_rd    = in_acc && !pass;
  end

  // advance position
  always_comb begin
    col_last = CMP_W'(col_q) + CMP_W'(1) >= w_eff;
    row_last = CMP_W'(row_q) + CMP_W'(1) >= h_eff;
    rib_last = {1'b0, rib_q} + (DIM_W + 1)'(1) >= {1'b0, bh_q};
    col_d  = col_q + COL_W'(1);
    row_d  = row_q;
    rib_d  = rib_q;
    bi_d   = bi_q;
    slot_d = slot_q;
    if (col_last) begin
      col_d = '0;
      if (row_last) begin
        row_d  = '0;
        rib_d  = '0;
        bi_d   = '0;
        slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
      end else begin
        row_d = row_q + ROW_W'(1);
        if (rib_last) begin
          rib_d = '0;
          if (bi_q < BAND_INDEX_MAX) bi_d = bi_q + BI_W'(1);
        end else begin
          rib_d = rib_q + DIM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
      rib_q  <= '0;
      bi_q   <= '0;
      fs_q   <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
      rib_q <= '0;
      bi_q  <= '0;
      fs_q  <= '0;
    end else if (in_acc) begin
      slot_q <= slot_d;
      col_q  <= col_d;
      row_q  <= row_d;
      rib_q  <= rib_d;
      bi_q   <= bi_d;
      fs_q   <= fs_d;
    end
  end

  // frame memory: write current slot, read delayed slot
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      frame_mem[slot_q][row_q][col_q] <= pix_i.pixel_in;
    end
    if (mem_rd) begin
      rdata_q <= frame_mem[rslot][row_q][col_q];
    end
  end

  assign adv1        = !vo_q || pix_o.ready;
  assign pix_i.ready = !v1_q || adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (in_acc)    v1_q <= 1'b1;
      else if (adv1) v1_q <= 1'b0;
      if (adv1)      vo_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix1_q  <= pix_i.pixel_in;
      pass1_q <= pass;
    end
    if (adv1 && v1_q) begin
      out_q <= pass1_q ? pix1_q : rdata_q;
    end
  end

  assign pix_o.valid     = vo_q;
  assign pix_o.pixel_out = out_q;

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(col_q) < w_eff)
    else $error("column counter beyond frame width");

  a_fs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    BK_W'(fs_q) <= bc_eff + BK_W'(1))
    else $error("frames_seen beyond saturation");

  a_rdata_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv1) |=> $stable(rdata_q))
    else $error("memory read data changed under stall");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (col_q == '0 && row_q == '0 && fs_q == '0 && bi_q == '0))
    else $error("register write did not restart stream");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v1_q)
    else $error("accepted word lost from read stage");

endmodule

FILE: verif/tb_rolling_shutter_band_delay_top.sv
// Testbench for rolling_shutter_band_delay_top: pixel streams over many register
// settings, each output word checked against an in-bench band delay predictor.
// Depends on rsbd_pkg, the channel interfaces in rsbd_if and the design top.
`timescale 1ns / 1ps

module tb_rolling_shutter_band_delay_top;
  import rsbd_pkg::*;

  localparam int NBANDS       = 8;
  localparam int NCOLS        = 64;
  localparam int NROWS        = 64;
  localparam int SLOT_WORDS   = NCOLS * NROWS;
  localparam int RUN_PIXELS   = 450;
  localparam int MAX_GAP      = 18;
  localparam int STALL_CYCLES = 300;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {GAP_NONE, GAP_SPARSE, GAP_FULL} gap_mode_e;

  logic clk_i;
  logic rst_ni;

  rsbd_in_if  in_ch ();
  rsbd_out_if out_ch ();
  rsbd_cfg_if cfg_ch ();

  rolling_shutter_band_delay_top #(
    .MAX_BANDS (NBANDS),
    .MAX_WIDTH (NCOLS),
    .MAX_HEIGHT(NROWS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .pix_i (in_ch),
    .pix_o (out_ch)
  );

  // band delay predictor state
  logic [PIX_W-1:0] frame_mem [NBANDS*SLOT_WORDS];
  int unsigned      wr_slot;
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      band_row;
  int unsigned      band_num;
  int unsigned      frames_started;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [BC_W-1:0]  bands_reg;
  logic [DIM_W-1:0] band_h_reg;

  logic [PIX_W-1:0] pending_pix [$];
  logic [PIX_W-1:0] expected_pix [$];

  gap_mode_e in_mode;
  gap_mode_e out_mode;
  int        in_wait;
  int        out_wait;
  logic      out_hold;
  int        stall_mark;

  int pix_queued;
  int pix_sent;
  int pix_recv;
  int reg_writes;
  int settings;
  int errors;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void queue_pixel(input logic [PIX_W-1:0] pix);
    pending_pix = {pending_pix, pix};
    pix_queued++;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FRAME_WIDTH:  width_reg = val[DIM_W-1:0];
      REG_FRAME_HEIGHT: height_reg = val[DIM_W-1:0];
      REG_BAND_COUNT:   bands_reg = val[BC_W-1:0];
      REG_BAND_HEIGHT:  band_h_reg = val[DIM_W-1:0];
      default:          return;
    endcase
    col_pos = 0;
    row_pos = 0;
    band_row = 0;
    band_num = 0;
    frames_started = 0;
  endfunction

  function automatic void delay_pixel(input logic [PIX_W-1:0] pix);
    int unsigned      w;
    int unsigned      h;
    int unsigned      bc;
    int unsigned      addr;
    int unsigned      lag;
    int unsigned      src;
    logic [PIX_W-1:0] word;
    w = clamp_size(width_reg, NCOLS);
    h = clamp_size(height_reg, NROWS);
    bc = clamp_size(bands_reg, NBANDS);
    addr = row_pos * NCOLS + col_pos;
    word = pix;
    if (col_pos == 0 && row_pos == 0 && frames_started < bc + 1) frames_started++;
    frame_mem[wr_slot * SLOT_WORDS + addr] = pix;
    if (frames_started > bc && band_h_reg != 0 && band_num < bc) begin
      lag = bc - 1 - band_num;
      src = (wr_slot + NBANDS - lag) % NBANDS;
      word = frame_mem[src * SLOT_WORDS + addr];
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        band_row = 0;
        band_num = 0;
        wr_slot = (wr_slot + 1) % NBANDS;
      end else begin
        row_pos++;
        if (band_row + 1 >= band_h_reg) begin
          band_row = 0;
          if (band_num < BAND_INDEX_MAX) band_num++;
        end else begin
          band_row++;
        end
      end
    end else begin
      col_pos++;
    end
    expected_pix = {expected_pix, word};
  endfunction

  function automatic int draw_gap(gap_mode_e mode);
    case (mode)
      GAP_NONE:   return 0;
      GAP_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
      default:    return $urandom_range(0, MAX_GAP);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic void flag_error(string what, logic [PIX_W-1:0] want,
                                     logic [PIX_W-1:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s at output word %0d: expected %06h, got %06h",
               $time, what, pix_recv, want, got);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.pixel_in <= '0;
      in_wait = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        delay_pixel(in_ch.pixel_in);
        pix_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_ch.valid <= 1'b0;
        end else if (pending_pix.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.pixel_in <= pending_pix.pop_front();
          in_wait = draw_gap(in_mode);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        pix_recv++;
        if (expected_pix.size() == 0) begin
          flag_error("unexpected word", '0, out_ch.pixel_out);
        end else begin
          if (out_ch.pixel_out !== expected_pix[0])
            flag_error("pixel mismatch", expected_pix[0], out_ch.pixel_out);
          void'(expected_pix.pop_front());
        end
        out_wait = draw_gap(out_mode);
      end
      if (out_hold) begin
        out_ch.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // hold the output off long enough for the block to back up its input
  initial begin
    out_hold = 1'b0;
    wait (stall_mark != 0 && pix_sent >= stall_mark);
    out_hold <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk_i);
    out_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d words still expected", expected_pix.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pix_recv < pix_queued);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.reg_data <= val;
    do @(posedge clk_i);
    while (!cfg_ch.ready);
    apply_reg(idx, val);
    reg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] wv, input logic [CFG_DATA_W-1:0] hv,
                           input logic [CFG_DATA_W-1:0] bv, input logic [CFG_DATA_W-1:0] hbv,
                           input int extra_frames, input bit partial,
                           input gap_mode_e im, input gap_mode_e om, input bit stall,
                           output int npix);
    int unsigned start;
    int unsigned fp;
    int unsigned nframes;
    wait_idle();
    in_mode = im;
    out_mode = om;
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_BAND_HEIGHT + CFG_IDX_W'($urandom_range(1, 252)), CFG_DATA_W'($urandom));
    start = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      case ((start + k) % 4)
        0:       write_reg(REG_FRAME_WIDTH, wv);
        1:       write_reg(REG_FRAME_HEIGHT, hv);
        2:       write_reg(REG_BAND_COUNT, bv);
        default: write_reg(REG_BAND_HEIGHT, hbv);
      endcase
    end
    settings++;
    fp = clamp_size(width_reg, NCOLS) * clamp_size(height_reg, NROWS);
    nframes = clamp_size(bands_reg, NBANDS) + 1 + extra_frames;
    npix = nframes * fp + (partial ? $urandom_range(1, fp) : 0);
    if (stall) stall_mark = pix_sent + 60;
    repeat (npix) queue_pixel(rand_pixel());
  endtask

  initial begin
    int          phase_pix;
    int          random_pix;
    int unsigned bc;
    int unsigned dim_hi;
    logic [CFG_DATA_W-1:0] wv;
    logic [CFG_DATA_W-1:0] hv;
    logic [CFG_DATA_W-1:0] bv;
    logic [CFG_DATA_W-1:0] hbv;

    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.pixel_in = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.reg_data = '0;
    width_reg = RST_FRAME_WIDTH;
    height_reg = RST_FRAME_HEIGHT;
    bands_reg = RST_BAND_COUNT;
    band_h_reg = RST_BAND_HEIGHT;
    wr_slot = 0;
    col_pos = 0;
    row_pos = 0;
    band_row = 0;
    band_num = 0;
    frames_started = 0;
    in_mode = GAP_NONE;
    out_mode = GAP_SPARSE;
    stall_mark = 0;
    pix_queued = 0;
    pix_sent = 0;
    pix_recv = 0;
    reg_writes = 0;
    settings = 1;
    errors = 0;
    random_pix = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // pixel field extremes under the reset settings
    queue_pixel(24'h000000);
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'hAAAAAA);
    queue_pixel(24'h555555);
    queue_pixel(24'h000001);
    queue_pixel(24'h800000);
    queue_pixel(24'h7FFFFF);
    queue_pixel(24'hFFFFFE);
    queue_pixel(24'h0F0F0F);
    queue_pixel(24'hF0F0F0);

    // widest rows with full history, output held off mid-stream
    run_phase(8'd64, 8'd1, 8'd8, 8'd1, 1, 1'b0, GAP_NONE, GAP_SPARSE, 1'b1, phase_pix);
    // tallest frame, two bands and pass-through rows below them
    run_phase(8'd1, 8'd64, 8'd2, 8'd20, 1, 1'b1, GAP_FULL, GAP_FULL, 1'b0, phase_pix);
    // zero width and height, band count past the limit, effect off
    run_phase(8'h80, 8'h00, 8'h0F, 8'h00, 1, 1'b0, GAP_SPARSE, GAP_NONE, 1'b0, phase_pix);
    run_phase(8'd2, 8'd2, 8'hFF, 8'd1, 1, 1'b1, GAP_FULL, GAP_SPARSE, 1'b0, phase_pix);
    // zero band count, oversized band height
    run_phase(8'd3, 8'd3, 8'h00, 8'h7F, 1, 1'b0, GAP_NONE, GAP_FULL, 1'b0, phase_pix);
    // width and height beyond the maximum
    run_phase(8'h7F, 8'd1, 8'd1, 8'd64, 0, 1'b0, GAP_SPARSE, GAP_SPARSE, 1'b0, phase_pix);
    run_phase(8'd1, 8'hFF, 8'd1, 8'd0, 0, 1'b0, GAP_FULL, GAP_NONE, 1'b0, phase_pix);

    while (random_pix < RUN_PIXELS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: bc = $urandom_range(1, 4);
        6, 7:             bc = $urandom_range(5, 8);
        8:                bc = 0;
        default:          bc = $urandom_range(9, 15);
      endcase
      dim_hi = (clamp_size(bc, NBANDS) > 4) ? 3 : 6;
      wv = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, dim_hi));
      hv = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, dim_hi));
      case ($urandom_range(0, 7))
        0:       hbv = 8'd0;
        1:       hbv = 8'($urandom_range(1, 64));
        default: hbv = 8'($urandom_range(1, 3));
      endcase
      wv[7] = 1'($urandom);
      hv[7] = 1'($urandom);
      hbv[7] = 1'($urandom);
      bv = {4'($urandom), 4'(bc)};
      run_phase(wv, hv, bv, hbv, $urandom_range(0, 2), $urandom_range(0, 3) == 0,
                gap_mode_e'($urandom_range(0, 2)), gap_mode_e'($urandom_range(0, 2)),
                1'b0, phase_pix);
      random_pix += phase_pix;
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    errors += expected_pix.size();

    $display("Streamed %0d pixel words through %0d register settings (%0d register writes),",
             pix_sent, settings, reg_writes);
    $display("%0d output words checked, one %0d-cycle output hold, %0d mismatches.",
             pix_recv, STALL_CYCLES, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
